// File: sv/sop_pkg.sv
// ----------------------------------------------------------------------------
// sop_pkg
// types and constants for the sphere overlap push-back pipeline
// ----------------------------------------------------------------------------
package sop_pkg;

  localparam int COORD_W  = 24;
  localparam int RAD_W    = 22;
  localparam int DIFF_W   = 25;
  localparam int RSUM_W   = 23;
  localparam int SQ_W     = 50;
  localparam int RSQ_W    = 46;
  localparam int REM_W    = 28;
  localparam int PROD_W   = 48;
  localparam int QUO_W    = 24;
  localparam int IN_W     = 168;
  localparam int OUT_W    = 80;

  localparam int ST_SQ    = 2;
  localparam int ST_SUM   = 3;
  localparam int ST_CMP   = 4;
  localparam int ST_SQRT0 = 5;
  localparam int ST_PROD  = ST_SQRT0 + DIFF_W;
  localparam int ST_DIV0  = ST_PROD + 1;
  localparam int ST_LAST  = ST_DIV0 + QUO_W - 1;

  typedef struct packed {
    logic                           hit;
    logic [2:0]                     neg;
    logic [2:0][DIFF_W-1:0]         mag;
    logic [RSUM_W-1:0]              rsum;
    logic [2:0][SQ_W-1:0]           sq;
    logic [SQ_W-1:0]                rad;
    logic [RSQ_W-1:0]               rsum2;
    logic [REM_W-1:0]               rem;
    logic [DIFF_W-1:0]              root;
    logic [2:0][QUO_W-1:0]          plo;
    logic [2:0][DIFF_W-1:0]         drem;
    logic [2:0][QUO_W-1:0]          quo;
  } pipe_t;

  function automatic pipe_t sop_step(int k, pipe_t s);
    pipe_t                 r;
    logic [REM_W-1:0]      sh;
    logic [REM_W-1:0]      trial;
    logic [RSUM_W-1:0]     t;
    logic [PROD_W-1:0]     prod;
    logic [DIFF_W:0]       dsh;
    r = s;
    sh = '0;
    trial = '0;
    t = '0;
    prod = '0;
    dsh = '0;
    if (k == ST_SQ) begin
      for (int i = 0; i < 3; i++) begin
        r.sq[i] = SQ_W'(s.mag[i]) * SQ_W'(s.mag[i]);
      end
    end else if (k == ST_SUM) begin
      r.rad   = s.sq[0] + s.sq[1] + s.sq[2];
      r.rsum2 = RSQ_W'(s.rsum) * RSQ_W'(s.rsum);
      r.rem   = '0;
      r.root  = '0;
    end else if (k == ST_CMP) begin
      r.hit = (s.rad <= SQ_W'(s.rsum2));
    end else if (k >= ST_SQRT0 && k < ST_PROD) begin
      sh    = {s.rem[REM_W-3:0], s.rad[SQ_W-1:SQ_W-2]};
      trial = {1'b0, s.root, 2'b01};
      r.rad = {s.rad[SQ_W-3:0], 2'b00};
      if (sh >= trial) begin
        r.rem  = sh - trial;
        r.root = {s.root[DIFF_W-2:0], 1'b1};
      end else begin
        r.rem  = sh;
        r.root = {s.root[DIFF_W-2:0], 1'b0};
      end
    end else if (k == ST_PROD) begin
      t = s.rsum - s.root[RSUM_W-1:0];
      for (int i = 0; i < 3; i++) begin
        prod      = PROD_W'(s.mag[i]) * PROD_W'(t);
        r.drem[i] = {1'b0, prod[PROD_W-1:QUO_W]};
        r.plo[i]  = prod[QUO_W-1:0];
        r.quo[i]  = '0;
      end
    end else if (k >= ST_DIV0 && k <= ST_LAST) begin
      for (int i = 0; i < 3; i++) begin
        dsh      = {s.drem[i], s.plo[i][QUO_W-1]};
        r.plo[i] = {s.plo[i][QUO_W-2:0], 1'b0};
        if (dsh >= {1'b0, s.root}) begin
          r.drem[i] = DIFF_W'(dsh - {1'b0, s.root});
          r.quo[i]  = {s.quo[i][QUO_W-2:0], 1'b1};
        end else begin
          r.drem[i] = DIFF_W'(dsh);
          r.quo[i]  = {s.quo[i][QUO_W-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

endpackage

// File: sv/sphere_overlap_pushback_top.sv
// ----------------------------------------------------------------------------
// sphere_overlap_pushback_top
// sphere against sphere overlap test with push-back vector, Q12.12
// ----------------------------------------------------------------------------
// Takes one pair test per cycle while s_axis_tready is high and returns one
// result per request, in order, through 55 registers: one stage for the
// difference, one for the squares, one for the sums, one compare, 25 stages
// of a pipelined square root (one root bit each), one product stage, 24
// stages of a pipelined divider (one quotient bit each, three lanes), and the
// output register. Every stage has its own valid bit and advances whenever the
// stage after it is empty or moving, so bubbles close up under backpressure.
// own_radius is written through cfg_we/cfg_wdata; the user must write it only
// while the pipeline is empty, as the block itself does not enforce this.
module sphere_overlap_pushback_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [sop_pkg::RAD_W-1:0]  cfg_wdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // query_x, query_y, query_z, query_radius, object_x, object_y, object_z
  input  logic [sop_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // hit, push_x, push_y, push_z
  output logic [sop_pkg::OUT_W-1:0]  m_axis_tdata
);
  import sop_pkg::*;

  logic [RAD_W-1:0]    own_radius;
  pipe_t               p    [1:ST_LAST];
  pipe_t               nxt  [1:ST_LAST];
  logic                pv   [1:ST_LAST];
  logic                en   [1:ST_LAST+1];
  logic                out_v;
  logic [OUT_W-1:0]    out_d;
  logic [OUT_W-1:0]    out_next;

  logic signed [DIFF_W-1:0] diff [3];
  logic [COORD_W-1:0]       qc   [3];
  logic [COORD_W-1:0]       oc   [3];

  assign qc[0] = s_axis_tdata[23:0];
  assign qc[1] = s_axis_tdata[47:24];
  assign qc[2] = s_axis_tdata[71:48];
  assign oc[0] = s_axis_tdata[117:94];
  assign oc[1] = s_axis_tdata[141:118];
  assign oc[2] = s_axis_tdata[165:142];

  always_ff @(posedge clk) begin
    if (rst) begin
      own_radius <= '0;
    end else if (cfg_we) begin
      own_radius <= cfg_wdata;
    end
  end

  always_comb begin
    nxt[1] = '0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = DIFF_W'(signed'(qc[i])) - DIFF_W'(signed'(oc[i]));
      nxt[1].neg[i] = diff[i][DIFF_W-1];
      nxt[1].mag[i] = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
    end
    nxt[1].rsum = RSUM_W'(own_radius) + RSUM_W'(s_axis_tdata[93:72]);
  end

  for (genvar k = 2; k <= ST_LAST; k++) begin : g_stage
    always_comb nxt[k] = sop_step(k, p[k-1]);
  end

  assign en[ST_LAST+1] = !out_v || m_axis_tready;
  for (genvar k = 1; k <= ST_LAST; k++) begin : g_reg
    assign en[k] = !pv[k] || en[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k] <= 1'b0;
      end else if (en[k]) begin
        pv[k] <= (k == 1) ? s_axis_tvalid : pv[k-1 > 0 ? k-1 : 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        p[k] <= nxt[k];
      end
    end
  end

  always_comb begin
    out_next = '0;
    out_next[0] = p[ST_LAST].hit;
    if (p[ST_LAST].hit && p[ST_LAST].root != '0) begin
      for (int i = 0; i < 3; i++) begin
        out_next[1 + i*COORD_W +: COORD_W] = p[ST_LAST].neg[i] ?
          COORD_W'(-p[ST_LAST].quo[i]) : COORD_W'(p[ST_LAST].quo[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en[ST_LAST+1]) begin
      out_v <= pv[ST_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_LAST+1]) begin
      out_d <= out_next;
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_d;

endmodule
